// ----- src/vfc_pkg.sv -----
// shared constants and types for the view facing triangle cull block
package vfc_pkg;

  // configuration register indexes
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_VIEW_X = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_VIEW_Y = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_VIEW_Z = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_COS_THR = 2'd3;

  // threshold format
  localparam int THR_W = 16;
  localparam int COS_FRAC = 14;
  localparam int TSQ_W = 31;

  localparam int TAG_W = 16;

  // limb width of the pipelined multipliers
  localparam int MUL_LIMB = 24;

  // request queue between classifier and output stage
  localparam int QAW = 5;
  localparam int QDEPTH = 1 << QAW;

  typedef struct packed {
    logic [QAW:0] fill;
    logic [QAW:0] decided;
  } vfc_qstat_t;

endpackage

// ----- src/vfc_ifs.sv -----
// request channels: triangle in, kept triangle out
interface vfc_in_if #(parameter int COORD_BITS = 16);
  logic valid;
  logic ready;
  logic signed [COORD_BITS-1:0] ax, ay, az, bx, by, bz, cx, cy, cz;
  logic [vfc_pkg::TAG_W-1:0] tri_tag;
  modport source (output valid, ax, ay, az, bx, by, bz, cx, cy, cz, tri_tag, input ready);
  modport sink (input valid, ax, ay, az, bx, by, bz, cx, cy, cz, tri_tag, output ready);
endinterface

interface vfc_out_if #(parameter int COORD_BITS = 16);
  logic valid;
  logic ready;
  logic signed [COORD_BITS-1:0] out_ax, out_ay, out_az, out_bx, out_by, out_bz;
  logic signed [COORD_BITS-1:0] out_cx, out_cy, out_cz;
  logic [vfc_pkg::TAG_W-1:0] out_tag;
  modport source (output valid, out_ax, out_ay, out_az, out_bx, out_by, out_bz,
                  out_cx, out_cy, out_cz, out_tag, input ready);
  modport sink (input valid, out_ax, out_ay, out_az, out_bx, out_by, out_bz,
                out_cx, out_cy, out_cz, out_tag, output ready);
endinterface

// ----- src/vfc_umul.sv -----
// pipelined unsigned multiplier lanes: limb partial products and a registered adder tree
module vfc_umul #(
  parameter int LANES = 1,
  parameter int AW = 8,
  parameter int BW = 8,
  parameter int SW = 1
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_vld,
  input  logic [AW-1:0]       a [LANES],
  input  logic [BW-1:0]       b [LANES],
  input  logic [SW-1:0]       side,
  output logic                out_vld,
  output logic [AW+BW-1:0]    p [LANES],
  output logic [SW-1:0]       out_side
);
  localparam int LB = vfc_pkg::MUL_LIMB;
  localparam int NA = (AW + LB - 1) / LB;
  localparam int NB = (BW + LB - 1) / LB;
  localparam int NPP = NA * NB;
  localparam int LEVELS = $clog2(NPP);
  localparam int NP2 = 1 << LEVELS;
  localparam int PPW = (NA + NB) * LB;
  localparam int STAGES = LEVELS + 1;

  logic [NA*LB-1:0] ap [LANES];
  logic [NB*LB-1:0] bp [LANES];
  logic [PPW-1:0]   tree [LANES][LEVELS+1][NP2];
  logic             vpipe [STAGES];
  logic [SW-1:0]    spipe [STAGES];

  for (genvar l = 0; l < LANES; l++) begin : g_lane
    assign ap[l] = (NA*LB)'(a[l]);
    assign bp[l] = (NB*LB)'(b[l]);
    for (genvar i = 0; i < NA; i++) begin : g_ai
      for (genvar j = 0; j < NB; j++) begin : g_bj
        always_ff @(posedge clk) begin
          tree[l][0][i*NB+j] <= PPW'((2*LB)'(ap[l][i*LB +: LB]) *
                                     (2*LB)'(bp[l][j*LB +: LB])) << (LB * (i + j));
        end
      end
    end
    for (genvar x = NPP; x < NP2; x++) begin : g_pad
      always_ff @(posedge clk) begin
        tree[l][0][x] <= '0;
      end
    end
    for (genvar k = 0; k < LEVELS; k++) begin : g_lvl
      for (genvar x = 0; x < NP2; x++) begin : g_node
        if (x < (NP2 >> (k + 1))) begin : g_add
          always_ff @(posedge clk) begin
            tree[l][k+1][x] <= tree[l][k][2*x] + tree[l][k][2*x+1];
          end
        end else begin : g_zero
          always_ff @(posedge clk) begin
            tree[l][k+1][x] <= '0;
          end
        end
      end
    end
    assign p[l] = (AW+BW)'(tree[l][LEVELS][0]);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < STAGES; k++) vpipe[k] <= 1'b0;
    end else begin
      vpipe[0] <= in_vld;
      for (int k = 1; k < STAGES; k++) vpipe[k] <= vpipe[k-1];
    end
  end

  always_ff @(posedge clk) begin
    spipe[0] <= side;
    for (int k = 1; k < STAGES; k++) spipe[k] <= spipe[k-1];
  end

  assign out_vld = vpipe[STAGES-1];
  assign out_side = spipe[STAGES-1];
endmodule

// ----- src/vfc_front.sv -----
// classifier pipeline: view direction, face normal and exact cosine threshold test
module vfc_front #(
  parameter int COORD_BITS = 16
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_vld,
  input  logic signed [COORD_BITS-1:0]         v [9],
  input  logic signed [COORD_BITS-1:0]         view [3],
  input  logic signed [vfc_pkg::THR_W-1:0]     thr,
  output logic                                 dec_vld,
  output logic                                 dec_keep
);
  localparam int C = COORD_BITS;
  localparam int DW = C + 1;
  localparam int PCW = 2 * C + 2;
  localparam int NW = 2 * C + 3;
  localparam int DDW = 2 * C + 4;
  localparam int TW = 3 * C + 5;
  localparam int DSW = 3 * C + 7;
  localparam int NNW = 4 * C + 8;
  localparam int M2W = 4 * C + 8;
  localparam int LENW = 6 * C + 12;
  localparam int DSQW = 6 * C + 14;
  localparam int LHW = DSQW + 2 * vfc_pkg::COS_FRAC;
  localparam int TSQW = vfc_pkg::TSQ_W;
  localparam int RHW = TSQW + LENW;

  // stage 1: edge and view vectors
  logic signed [DW-1:0] dir1 [3], e1 [3], f1 [3];
  // stage 2: cross product terms and view squares
  logic signed [PCW-1:0] pc2 [6], dsq2 [3];
  logic signed [DW-1:0]  dir2 [3];
  // stage 3: normal and squared view length
  logic signed [NW-1:0]  n3 [3];
  logic signed [DW-1:0]  dir3 [3];
  logic [DDW-1:0]        dd3;
  // stage 4: magnitudes
  logic [NW-1:0]         na4 [3];
  logic [DW-1:0]         da4 [3];
  logic [2:0]            tsg4;
  logic [DDW-1:0]        dd4;
  // first multiplier group
  logic [NW-1:0]         m1a [6], m1b [6];
  logic [2*NW-1:0]       m1p [6];
  logic [DDW+2:0]        m1s;
  logic                  m1v;
  // stages 5 to 7
  logic signed [TW-1:0]  t5 [3];
  logic [NNW-1:0]        nn5, nn6;
  logic [DDW-1:0]        dd5, dd6;
  logic signed [DSW-1:0] d6;
  logic [M2W-1:0]        dabs7, nn7, dd7;
  logic                  dneg7;
  // second multiplier group
  logic [M2W-1:0]        m2a [2], m2b [2];
  logic [2*M2W-1:0]      m2p [2];
  logic                  m2s, m2v;
  // stage 8
  logic [LENW-1:0]       len8;
  logic                  lenz8, dneg8;
  logic [LHW-1:0]        lhs8;
  logic [TSQW-1:0]       tsq8;
  logic signed [31:0]    thr_sq;
  // third multiplier
  logic [TSQW-1:0]       m3a [1];
  logic [LENW-1:0]       m3b [1];
  logic [RHW-1:0]        m3p [1];
  logic [LHW+1:0]        m3s;
  logic                  m3v;
  logic [LHW-1:0]        lhs9;
  logic                  lenz9, dneg9, ge9, le9, keep9;
  logic                  v1, v2, v3, v4, v5, v6, v7, v8;

  assign thr_sq = thr * thr;

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      dir1[i] <= DW'(v[i]) - DW'(view[i]);
      e1[i] <= DW'(v[3+i]) - DW'(v[i]);
      f1[i] <= DW'(v[6+i]) - DW'(v[3+i]);
    end
    pc2[0] <= e1[1] * f1[2];
    pc2[1] <= e1[2] * f1[1];
    pc2[2] <= e1[2] * f1[0];
    pc2[3] <= e1[0] * f1[2];
    pc2[4] <= e1[0] * f1[1];
    pc2[5] <= e1[1] * f1[0];
    for (int i = 0; i < 3; i++) begin
      dsq2[i] <= dir1[i] * dir1[i];
      dir2[i] <= dir1[i];
      dir3[i] <= dir2[i];
      n3[i] <= NW'(pc2[2*i]) - NW'(pc2[2*i+1]);
      na4[i] <= n3[i][NW-1] ? NW'(-n3[i]) : NW'(n3[i]);
      da4[i] <= dir3[i][DW-1] ? DW'(-dir3[i]) : DW'(dir3[i]);
      tsg4[i] <= n3[i][NW-1] ^ dir3[i][DW-1];
    end
    dd3 <= DDW'(dsq2[0]) + DDW'(dsq2[1]) + DDW'(dsq2[2]);
    dd4 <= dd3;
    // signed terms of the dot product and squared normal length
    for (int i = 0; i < 3; i++) begin
      t5[i] <= m1s[i] ? -$signed(TW'(m1p[i])) : $signed(TW'(m1p[i]));
    end
    nn5 <= NNW'(m1p[3]) + NNW'(m1p[4]) + NNW'(m1p[5]);
    dd5 <= m1s[DDW+2:3];
    d6 <= DSW'(t5[0]) + DSW'(t5[1]) + DSW'(t5[2]);
    nn6 <= nn5;
    dd6 <= dd5;
    dabs7 <= M2W'(d6[DSW-1] ? -d6 : d6);
    dneg7 <= d6[DSW-1];
    nn7 <= M2W'(nn6);
    dd7 <= M2W'(dd6);
    len8 <= LENW'(m2p[0]);
    lenz8 <= (m2p[0] == '0);
    lhs8 <= LHW'(DSQW'(m2p[1])) << (2 * vfc_pkg::COS_FRAC);
    dneg8 <= m2s;
    tsq8 <= thr_sq[TSQW-1:0];
    if (lenz9) begin
      keep9 <= 1'b1;
    end else if (thr == '0) begin
      keep9 <= !dneg9;
    end else if (!thr[vfc_pkg::THR_W-1]) begin
      keep9 <= !dneg9 && ge9;
    end else begin
      keep9 <= !dneg9 || le9;
    end
  end

  for (genvar i = 0; i < 3; i++) begin : g_m1
    assign m1a[i] = NW'(da4[i]);
    assign m1b[i] = na4[i];
    assign m1a[3+i] = na4[i];
    assign m1b[3+i] = na4[i];
  end

  vfc_umul #(.LANES(6), .AW(NW), .BW(NW), .SW(DDW + 3)) u_mul_dot (
    .clk(clk), .rst(rst), .in_vld(v4), .a(m1a), .b(m1b), .side({dd4, tsg4}),
    .out_vld(m1v), .p(m1p), .out_side(m1s)
  );

  assign m2a[0] = dd7;
  assign m2b[0] = nn7;
  assign m2a[1] = dabs7;
  assign m2b[1] = dabs7;

  vfc_umul #(.LANES(2), .AW(M2W), .BW(M2W), .SW(1)) u_mul_len (
    .clk(clk), .rst(rst), .in_vld(v7), .a(m2a), .b(m2b), .side(dneg7),
    .out_vld(m2v), .p(m2p), .out_side(m2s)
  );

  assign m3a[0] = tsq8;
  assign m3b[0] = len8;

  vfc_umul #(.LANES(1), .AW(TSQW), .BW(LENW), .SW(LHW + 2)) u_mul_thr (
    .clk(clk), .rst(rst), .in_vld(v8), .a(m3a), .b(m3b), .side({lhs8, lenz8, dneg8}),
    .out_vld(m3v), .p(m3p), .out_side(m3s)
  );

  assign lhs9 = m3s[LHW+1:2];
  assign lenz9 = m3s[1];
  assign dneg9 = m3s[0];
  assign ge9 = RHW'(lhs9) >= m3p[0];
  assign le9 = RHW'(lhs9) <= m3p[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
      v6 <= 1'b0;
      v7 <= 1'b0;
      v8 <= 1'b0;
      dec_vld <= 1'b0;
    end else begin
      v1 <= in_vld;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
      v5 <= m1v;
      v6 <= v5;
      v7 <= v6;
      v8 <= m2v;
      dec_vld <= m3v;
    end
  end

  assign dec_keep = keep9;
endmodule

// ----- src/vfc_back.sv -----
// request queue with decision bits and the output register stage
module vfc_back #(
  parameter int PW = 160
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  logic [PW-1:0]       push_data,
  input  logic                dec_vld,
  input  logic                dec_keep,
  output logic                room,
  output vfc_pkg::vfc_qstat_t stat,
  output logic                out_vld,
  input  logic                out_rdy,
  output logic [PW-1:0]       out_data
);
  localparam int DEPTH = vfc_pkg::QDEPTH;
  localparam int QAW = vfc_pkg::QAW;

  logic [PW-1:0]  mem [DEPTH];
  logic           keepq [DEPTH];
  logic [QAW-1:0] wptr, dptr, rptr;
  logic [QAW:0]   fill, decided;
  logic           pop, head_keep;

  assign head_keep = keepq[rptr];
  assign pop = (decided != '0) && (!head_keep || !out_vld || out_rdy);
  assign room = fill < (QAW+1)'(DEPTH);
  assign stat.fill = fill;
  assign stat.decided = decided;

  always_ff @(posedge clk) begin
    if (push) mem[wptr] <= push_data;
    if (dec_vld) keepq[dptr] <= dec_keep;
    if (pop && head_keep) out_data <= mem[rptr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= '0;
      dptr <= '0;
      rptr <= '0;
      fill <= '0;
      decided <= '0;
      out_vld <= 1'b0;
    end else begin
      if (push) wptr <= wptr + 1'b1;
      if (dec_vld) dptr <= dptr + 1'b1;
      if (pop) rptr <= rptr + 1'b1;
      fill <= fill + (QAW+1)'(push) - (QAW+1)'(pop);
      decided <= decided + (QAW+1)'(dec_vld) - (QAW+1)'(pop);
      if (pop && head_keep) begin
        out_vld <= 1'b1;
      end else if (out_rdy) begin
        out_vld <= 1'b0;
      end
    end
  end
endmodule

// ----- src/view_facing_triangle_cull.sv -----
// top level of the view facing triangle cull block
// view facing triangle cull
// in_ch carries one triangle per request (vertices a, b, c and a tag); out_ch carries
// the triangles that face the viewer closely enough, unchanged and in arrival order.
// culled triangles simply produce no output request
// the cfg port writes viewer x, y, z and the cosine threshold (q1.14); the user
// must write them only while idle, which the block itself does not enforce
// throughput: one triangle per cycle while out_ch is ready; culled ones give no output
// from acceptance to out_ch.valid: the classifier pipeline (edge and cross product
// stages plus three limb multiplier trees whose depth grows with COORD_BITS), the
// queue that the decision lands in, then the output register
// the payload goes into a 32 entry queue on acceptance; the classifier decision joins
// it in order, so in_ch.ready drops only when the queue is full
// when out_ch stalls, the queue keeps absorbing triangles until it fills
// reset: synchronous, clears queue pointers, valid bits and config registers to zero
module view_facing_triangle_cull #(
  parameter int COORD_BITS = 16
) (
  input  logic                                  clk,
  input  logic                                  rst,
  vfc_in_if.sink                                in_ch,
  vfc_out_if.source                             out_ch,
  input  logic                                  cfg_we,
  input  logic [vfc_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [((COORD_BITS > vfc_pkg::THR_W) ? COORD_BITS : vfc_pkg::THR_W)-1:0] cfg_wdata
);
  localparam int C = COORD_BITS;
  localparam int TW = vfc_pkg::TAG_W;
  localparam int PW = 9 * C + TW;

  // configuration registers
  logic signed [C-1:0]                view [3];
  logic signed [vfc_pkg::THR_W-1:0]   cos_threshold;

  logic signed [C-1:0]  vin [9];
  logic                 in_fire;
  logic                 dec_vld, dec_keep, room;
  logic [PW-1:0]        push_data, out_data;
  vfc_pkg::vfc_qstat_t  qstat;

  // register writes, unknown indexes cannot occur with a two bit index
  always_ff @(posedge clk) begin
    if (rst) begin
      view[0] <= '0;
      view[1] <= '0;
      view[2] <= '0;
      cos_threshold <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        vfc_pkg::REG_VIEW_X:  view[0] <= cfg_wdata[C-1:0];
        vfc_pkg::REG_VIEW_Y:  view[1] <= cfg_wdata[C-1:0];
        vfc_pkg::REG_VIEW_Z:  view[2] <= cfg_wdata[C-1:0];
        vfc_pkg::REG_COS_THR: cos_threshold <= cfg_wdata[vfc_pkg::THR_W-1:0];
        default: ;
      endcase
    end
  end

  // accept while the queue has space for the request
  assign in_ch.ready = room;
  assign in_fire = in_ch.valid && room;

  assign vin[0] = in_ch.ax;
  assign vin[1] = in_ch.ay;
  assign vin[2] = in_ch.az;
  assign vin[3] = in_ch.bx;
  assign vin[4] = in_ch.by;
  assign vin[5] = in_ch.bz;
  assign vin[6] = in_ch.cx;
  assign vin[7] = in_ch.cy;
  assign vin[8] = in_ch.cz;

  assign push_data = {in_ch.tri_tag, in_ch.cz, in_ch.cy, in_ch.cx, in_ch.bz, in_ch.by,
                      in_ch.bx, in_ch.az, in_ch.ay, in_ch.ax};

  // front: keep or cull decision, fixed latency, never stalls
  vfc_front #(.COORD_BITS(C)) u_front (
    .clk(clk), .rst(rst), .in_vld(in_fire), .v(vin), .view(view),
    .thr(cos_threshold), .dec_vld(dec_vld), .dec_keep(dec_keep)
  );

  // back: payload queue, decision matching and output register
  vfc_back #(.PW(PW)) u_back (
    .clk(clk), .rst(rst), .push(in_fire), .push_data(push_data),
    .dec_vld(dec_vld), .dec_keep(dec_keep), .room(room), .stat(qstat),
    .out_vld(out_ch.valid), .out_rdy(out_ch.ready), .out_data(out_data)
  );

  assign out_ch.out_ax = out_data[0*C +: C];
  assign out_ch.out_ay = out_data[1*C +: C];
  assign out_ch.out_az = out_data[2*C +: C];
  assign out_ch.out_bx = out_data[3*C +: C];
  assign out_ch.out_by = out_data[4*C +: C];
  assign out_ch.out_bz = out_data[5*C +: C];
  assign out_ch.out_cx = out_data[6*C +: C];
  assign out_ch.out_cy = out_data[7*C +: C];
  assign out_ch.out_cz = out_data[8*C +: C];
  assign out_ch.out_tag = out_data[9*C +: TW];

`ifndef SYNTHESIS
  // a decision always belongs to a queued request that is still waiting
  a_dec_has_entry: assert property (@(posedge clk) disable iff (rst)
    dec_vld |-> (qstat.fill != '0))
    else $error("decision arrived with an empty queue");

  // decided entries never outnumber queued ones
  a_decided_le_fill: assert property (@(posedge clk) disable iff (rst)
    qstat.decided <= qstat.fill)
    else $error("more decisions than queued requests");

  // nothing leaves right after reset
  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !out_ch.valid)
    else $error("output valid after reset");
`endif
endmodule

// ----- bench/testbench.sv -----
// testbench for the view facing triangle cull block: directed table plus random triangles
`timescale 1ns / 100ps

module testbench;

  localparam int CB = 16;

  // one triangle request, packed so fields can be walked by index
  typedef struct packed {
    logic signed [CB-1:0]      ax, ay, az, bx, by, bz, cx, cy, cz;
    logic [vfc_pkg::TAG_W-1:0] tag;
  } tri_t;

  // what a directed row says about its outcome
  typedef enum logic [1:0] {PREDICT, KEPT, CULLED} verdict_t;

  typedef struct {
    tri_t     t;
    verdict_t v;
  } row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [vfc_pkg::CFG_IDX_W-1:0] cfg_index = vfc_pkg::REG_VIEW_X;
  logic [CB-1:0] cfg_wdata = '0;

  vfc_in_if  #(.COORD_BITS(CB)) in_ch ();
  vfc_out_if #(.COORD_BITS(CB)) out_ch ();

  view_facing_triangle_cull #(.COORD_BITS(CB)) uut (
    .clk(clk), .rst(rst), .in_ch(in_ch), .out_ch(out_ch),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  always #2 clk = ~clk;

  // our own copy of the registers
  logic signed [CB-1:0]             view_x = '0, view_y = '0, view_z = '0;
  logic signed [vfc_pkg::THR_W-1:0] cos_thr = '0;

  tri_t kept_q[$];
  int   errors = 0;
  int   send_idle = 0;
  int   recv_stall = 0;

  string fname[10] = '{"ax", "ay", "az", "bx", "by", "bz", "cx", "cy", "cz", "tag"};

  task automatic report(string what, logic [15:0] got, logic [15:0] want);
    $display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
    errors++;
  endtask

  // exact cosine test in wide integers: keep when 16384*d >= thr*sqrt(|dir|^2 |n|^2)
  function automatic bit faces_viewer(tri_t t);
    logic signed [255:0] dx, dy, dz, ex, ey, ez, fx, fy, fz, nx, ny, nz;
    logic signed [255:0] d, dd, nn, len, lhs, rhs, th;
    dx = t.ax - view_x; dy = t.ay - view_y; dz = t.az - view_z;
    ex = t.bx - t.ax; ey = t.by - t.ay; ez = t.bz - t.az;
    fx = t.cx - t.bx; fy = t.cy - t.by; fz = t.cz - t.bz;
    nx = ey * fz - ez * fy;
    ny = ez * fx - ex * fz;
    nz = ex * fy - ey * fx;
    d   = dx * nx + dy * ny + dz * nz;
    dd  = dx * dx + dy * dy + dz * dz;
    nn  = nx * nx + ny * ny + nz * nz;
    len = dd * nn;
    th  = cos_thr;
    // degenerate triangle or viewer sitting on the vertex
    if (len == 0) return 1'b1;
    if (th == 0) return d >= 0;
    if (th > 0 && d < 0) return 1'b0;
    if (th < 0 && d >= 0) return 1'b1;
    lhs = d * d * 256'sd268435456;
    rhs = th * th * len;
    // both sides non-negative here
    if (th > 0) return lhs >= rhs;
    return lhs <= rhs;
  endfunction

  // receiver: random back-pressure on the output channel
  always @(negedge clk) begin
    out_ch.ready <= rst ? 1'b1 : ($urandom_range(99) >= recv_stall);
  end

  // output checker: compare each kept triangle with the oldest expectation
  always @(posedge clk) begin
    tri_t got, want;
    if (!rst && out_ch.valid && out_ch.ready) begin
      got = '{out_ch.out_ax, out_ch.out_ay, out_ch.out_az, out_ch.out_bx, out_ch.out_by,
              out_ch.out_bz, out_ch.out_cx, out_ch.out_cy, out_ch.out_cz, out_ch.out_tag};
      if (kept_q.size() == 0) begin
        report("unexpected request", got.tag, 16'h0);
      end else begin
        want = kept_q.pop_front();
        for (int k = 0; k < 10; k++) begin
          if (got[159-16*k -: 16] !== want[159-16*k -: 16])
            report(fname[k], got[159-16*k -: 16], want[159-16*k -: 16]);
        end
      end
    end
  end

  // drive one triangle, holding it until accepted; called at a falling edge
  task automatic send_tri(tri_t t, verdict_t v);
    bit keep;
    while ($urandom_range(99) < send_idle) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid <= 1'b1;
    {in_ch.ax, in_ch.ay, in_ch.az, in_ch.bx, in_ch.by, in_ch.bz,
     in_ch.cx, in_ch.cy, in_ch.cz, in_ch.tri_tag} <= t;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    keep = (v == PREDICT) ? faces_viewer(t) : (v == KEPT);
    if (keep) kept_q.insert(kept_q.size(), t);
    @(negedge clk);
  endtask

  // drain outstanding requests and let the pipeline empty
  task automatic drain();
    in_ch.valid <= 1'b0;
    while (kept_q.size() != 0) @(negedge clk);
    // culled triangles may still be in flight
    repeat (40) @(negedge clk);
  endtask

  // leaves the write enable high; the caller drops it after the last write
  task automatic write_reg(logic [vfc_pkg::CFG_IDX_W-1:0] idx, logic [15:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    case (idx)
      vfc_pkg::REG_VIEW_X:  view_x = val;
      vfc_pkg::REG_VIEW_Y:  view_y = val;
      vfc_pkg::REG_VIEW_Z:  view_z = val;
      vfc_pkg::REG_COS_THR: cos_thr = val;
      default: ;
    endcase
  endtask

  task automatic set_view_thr(logic [15:0] vx, logic [15:0] vy, logic [15:0] vz,
                              logic [15:0] thr);
    drain();
    write_reg(vfc_pkg::REG_VIEW_X, vx);
    write_reg(vfc_pkg::REG_VIEW_Y, vy);
    write_reg(vfc_pkg::REG_VIEW_Z, vz);
    write_reg(vfc_pkg::REG_COS_THR, thr);
    cfg_we <= 1'b0;
  endtask

  // either full range coordinates or a small local cluster, which makes both
  // outcomes common
  function automatic tri_t rand_tri();
    tri_t t;
    int   base;
    t = {$urandom, $urandom, $urandom, $urandom, $urandom};
    if ($urandom_range(99) < 65) begin
      base = $urandom_range(0, 4000) - 2000;
      t.ax = CB'(base + $urandom_range(0, 1200) - 600);
      t.ay = CB'(base + $urandom_range(0, 1200) - 600);
      t.az = CB'(base + $urandom_range(0, 1200) - 600);
      t.bx = CB'(t.ax + $urandom_range(0, 1200) - 600);
      t.by = CB'(t.ay + $urandom_range(0, 1200) - 600);
      t.bz = CB'(t.az + $urandom_range(0, 1200) - 600);
      t.cx = CB'(t.ax + $urandom_range(0, 1200) - 600);
      t.cy = CB'(t.ay + $urandom_range(0, 1200) - 600);
      t.cz = CB'(t.az + $urandom_range(0, 1200) - 600);
    end
    return t;
  endfunction

  // directed rows at reset settings (viewer at origin, threshold zero)
  row_t reset_rows[] = '{
    '{'{16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0,
        16'h0000}, KEPT},
    '{'{-16'sd32768, -16'sd32768, -16'sd32768, -16'sd32768, -16'sd32768, -16'sd32768,
        -16'sd32768, -16'sd32768, -16'sd32768, 16'hffff}, KEPT},
    '{'{16'sd32767, 16'sd32767, 16'sd32767, 16'sd32767, 16'sd32767, 16'sd32767,
        16'sd32767, 16'sd32767, 16'sd32767, 16'h5a5a}, KEPT},
    // collinear vertices give a zero normal
    '{'{16'sd256, 16'sd0, 16'sd0, 16'sd512, 16'sd0, 16'sd0, 16'sd768, 16'sd0, 16'sd0,
        16'ha5a5}, KEPT},
    // facing towards and away with threshold zero
    '{'{16'sd0, 16'sd0, 16'sd256, 16'sd256, 16'sd0, 16'sd256, 16'sd256, 16'sd256,
        16'sd256, 16'h0001}, KEPT},
    '{'{16'sd0, 16'sd0, 16'sd256, 16'sd256, 16'sd256, 16'sd256, 16'sd256, 16'sd0,
        16'sd256, 16'h0002}, CULLED},
    // normal perpendicular to the view ray: cosine exactly zero
    '{'{16'sd256, 16'sd0, 16'sd0, 16'sd512, 16'sd0, 16'sd0, 16'sd512, 16'sd256, 16'sd0,
        16'h0003}, KEPT},
    '{'{-16'sd32768, 16'sd32767, -16'sd32768, 16'sd32767, -16'sd32768, 16'sd32767,
        -16'sd32768, -16'sd32768, 16'sd32767, 16'h8000}, PREDICT},
    '{'{16'sd32767, -16'sd32768, 16'sd32767, -16'sd32768, 16'sd32767, -16'sd32768,
        16'sd32767, 16'sd32767, -16'sd32768, 16'h7fff}, PREDICT},
    '{'{16'sd100, -16'sd200, 16'sd300, -16'sd50, 16'sd75, 16'sd20, 16'sd10, 16'sd999,
        -16'sd400, 16'h1234}, PREDICT}
  };

  // rows with the viewer at (0,0,-1.0) and threshold one
  row_t strict_rows[] = '{
    // normal parallel to the view ray: cosine equals the threshold
    '{'{16'sd0, 16'sd0, 16'sd0, 16'sd256, 16'sd0, 16'sd0, 16'sd256, 16'sd256, 16'sd0,
        16'h0010}, KEPT},
    // reversed winding
    '{'{16'sd0, 16'sd0, 16'sd0, 16'sd256, 16'sd256, 16'sd0, 16'sd256, 16'sd0, 16'sd0,
        16'h0011}, CULLED},
    // viewer sits on the first vertex
    '{'{16'sd0, 16'sd0, -16'sd256, 16'sd256, 16'sd0, 16'sd0, 16'sd9, 16'sd256, 16'sd0,
        16'h0012}, KEPT},
    // slightly tilted, just short of parallel
    '{'{16'sd0, 16'sd0, 16'sd0, 16'sd256, 16'sd0, 16'sd1, 16'sd256, 16'sd256, 16'sd0,
        16'h0013}, CULLED},
    '{'{16'sd50, 16'sd60, 16'sd70, 16'sd300, 16'sd40, 16'sd20, 16'sd280, 16'sd350,
        16'sd90, 16'h0014}, PREDICT}
  };

  initial begin
    logic [15:0] thr;
    in_ch.valid = 1'b0;
    {in_ch.ax, in_ch.ay, in_ch.az, in_ch.bx, in_ch.by, in_ch.bz,
     in_ch.cx, in_ch.cy, in_ch.cz, in_ch.tri_tag} = '0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed part at reset values
    send_idle = 8;
    recv_stall = 45;
    foreach (reset_rows[i]) send_tri(reset_rows[i].t, reset_rows[i].v);
    set_view_thr(16'h0000, 16'h0000, -16'sd256, 16'sd16384);
    foreach (strict_rows[i]) send_tri(strict_rows[i].t, strict_rows[i].v);

    // random phases: idling profile moves from sender-light to receiver-light to none;
    // thresholds cover the range ends and values beyond them
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: thr = 16'($urandom_range(0, 32768) - 16384);
        1: thr = -16'sd16384;
        2: thr = 16'sd32767;
        3: thr = -16'sd32768;
        4: thr = 16'sd0;
        default: thr = 16'($urandom_range(0, 32768) - 16384);
      endcase
      if (ph == 5)
        set_view_thr(16'($urandom), 16'($urandom), 16'($urandom), thr);
      else
        set_view_thr(16'($urandom_range(0, 4000) - 2000),
                     16'($urandom_range(0, 4000) - 2000),
                     16'($urandom_range(0, 4000) - 2000), thr);
      send_idle  = (ph < 2) ? 8 : (ph < 4) ? 45 : 0;
      recv_stall = (ph < 2) ? 45 : (ph < 4) ? 8 : 0;
      for (int n = 0; n < 150; n++) begin
        send_tri(rand_tri(), PREDICT);
        // a hold-off that lets the output side run completely dry
        if (ph == 0 && n == 75) drain();
      end
    end

    drain();
    if (errors == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

  // guard against a hang
  initial begin
    #2000000;
    $display("tb: failure");
    $finish;
  end

endmodule

// ----- sim.f -----
src/vfc_pkg.sv
src/vfc_ifs.sv
src/vfc_umul.sv
src/vfc_front.sv
src/vfc_back.sv
src/view_facing_triangle_cull.sv
bench/testbench.sv
